### rtl/assert_macros.svh
// assertion macros used by the trainer top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KMTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KMTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KMTC_ASSERT(lbl, prop, msg)
`define KMTC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/kmtc_pkg.sv
// types, constants and helpers of the codebook trainer
package kmtc_pkg;
  localparam int CODEBOOK_MAX = 32;
  localparam int TRAIN_MAX    = 4096;
  localparam int DIMENSIONS   = 12;
  localparam int MAX_ITER     = 255;

  localparam int TA_W  = $clog2(TRAIN_MAX * DIMENSIONS);
  localparam int CA_W  = $clog2(CODEBOOK_MAX * DIMENSIONS);
  localparam int J_W   = (CODEBOOK_MAX > 1) ? $clog2(CODEBOOK_MAX) : 1;
  localparam int V_W   = $clog2(TRAIN_MAX);
  localparam int D_W   = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
  localparam int PC_W  = $clog2(MAX_ITER + 1);
  localparam int SUM_W = 29;
  localparam int CNT_W = 13;
  localparam int ACC_W = 44;
  localparam int DS_W  = 56;

  localparam logic [1:0] REQ_LOAD_TRAIN = 2'd0;
  localparam logic [1:0] REQ_LOAD_CODE  = 2'd1;
  localparam logic [1:0] REQ_START      = 2'd2;
  localparam logic [1:0] REQ_READ_CODE  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_LIMIT = 2'd2;

  localparam logic [1:0] CFG_CODEBOOK_SIZE  = 2'd0;
  localparam logic [1:0] CFG_TRAINING_COUNT = 2'd1;
  localparam logic [1:0] CFG_STOP_THRESHOLD = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [11:0]        vec_index;
    logic [3:0]         dim_index;
    logic signed [15:0] coef_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] read_value;
    logic [47:0]        avg_distortion;
    logic [7:0]         iterations;
  } rsp_t;

  function automatic logic [5:0] weight_of(input logic [D_W-1:0] d);
    logic [5:0] w;
    case (d)
      4'd0:    w = 6'd1;
      4'd1:    w = 6'd3;
      4'd2:    w = 6'd7;
      4'd3:    w = 6'd13;
      4'd4:    w = 6'd19;
      4'd5:    w = 6'd22;
      4'd6:    w = 6'd25;
      4'd7:    w = 6'd33;
      4'd8:    w = 6'd42;
      4'd9:    w = 6'd50;
      4'd10:   w = 6'd56;
      default: w = 6'd61;
    endcase
    return w;
  endfunction
endpackage

### rtl/kmtc_ram.sv
// generic single-write, single-read ram with registered read
module kmtc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/kmeans_tokhura_codebook_trainer_unit.sv
// top level of the k-means codebook trainer with tokhura-weighted distance
//
//  channel | ports                         | direction | item
//  in      | in_valid in_stall in_data     | in        | load / start / read request
//  out     | out_valid out_stall out_data  | out       | one result per request
//  cfg     | cfg_we cfg_index cfg_wdata    | in        | register write, no read-back
//
// a load's result is registered as it is taken, a codeword read adds the S_RDW wait state;
// a stalled result holds off the next request; a pass reads one coefficient at a time
//   through S_DADDR, S_DSQ and S_DACC and the single read port of each ram
// the codebook update sends each coefficient through the shared divider
// rst_n is synchronous; no clearing pass, rams hold undefined data until loaded
// in_stall is high while training or reading, or while a result is stalled
module kmeans_tokhura_codebook_trainer_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  kmtc_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output kmtc_pkg::rsp_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_wdata
);
`include "assert_macros.svh"

  localparam int DIMS    = kmtc_pkg::DIMENSIONS;
  localparam int TA_W    = kmtc_pkg::TA_W;
  localparam int CA_W    = kmtc_pkg::CA_W;
  localparam int J_W     = kmtc_pkg::J_W;
  localparam int V_W     = kmtc_pkg::V_W;
  localparam int D_W     = kmtc_pkg::D_W;
  localparam int PC_W    = kmtc_pkg::PC_W;
  localparam int SUM_W   = kmtc_pkg::SUM_W;
  localparam int CNT_W   = kmtc_pkg::CNT_W;
  localparam int ACC_W   = kmtc_pkg::ACC_W;
  localparam int DS_W    = kmtc_pkg::DS_W;
  localparam int DIV_CW  = $clog2(DS_W);

  typedef enum logic [3:0] {
    S_IDLE, S_RDW, S_CLR, S_DADDR, S_DSQ, S_DACC, S_UADDR, S_UWR,
    S_DIV, S_CA, S_CC, S_CS, S_CD, S_CW
  } state_t;

  state_t state_r;

  // configuration
  logic [5:0]  k_r;
  logic [12:0] n_r;
  logic [31:0] thr_r;

  // loop counters and bases
  logic [V_W:0]     v_r;
  logic [J_W-1:0]   j_r;
  logic [D_W-1:0]   d_r;
  logic [CA_W-1:0]  clr_r;
  logic [TA_W-1:0]  tv_base_r;
  logic [CA_W-1:0]  cb_base_r;
  logic [CA_W-1:0]  bj_base_r;
  logic [J_W-1:0]   bj_r;

  // distance datapath
  logic [33:0]      sq_r;
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] best_r;
  logic [DS_W-1:0]  dsum_r;

  // pass bookkeeping
  logic             first_r;
  logic [PC_W-1:0]  pc_r;
  logic [47:0]      prev_r;

  // shared divider
  logic [DS_W-1:0]  num_r;
  logic [CNT_W-1:0] den_r;
  logic [CNT_W-1:0] rem_r;
  logic [DIV_CW-1:0] div_cnt_r;
  logic             div_avg_r;
  logic             neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic [15:0]      cw_val_r;

  logic             out_valid_r;
  kmtc_pkg::rsp_t   out_data_r;

  // ram ports
  logic             tr_we;
  logic [TA_W-1:0]  tr_waddr, tr_raddr;
  logic [15:0]      tr_rdata;
  logic             cb_we;
  logic [CA_W-1:0]  cb_waddr, cb_raddr;
  logic [15:0]      cb_wdata, cb_rdata;
  logic             sm_we;
  logic [CA_W-1:0]  sm_waddr, sm_raddr;
  logic [SUM_W-1:0] sm_wdata, sm_rdata;
  logic             ct_we;
  logic [J_W-1:0]   ct_waddr, ct_raddr;
  logic [CNT_W-1:0] ct_wdata, ct_rdata;

  logic             accept;
  logic             in_vec_ok, in_cw_ok, start_ok;
  logic [TA_W-1:0]  in_taddr;
  logic [CA_W-1:0]  in_caddr;
  logic             last_d, last_j, last_v, last_clr;
  logic signed [16:0] diff;
  logic [39:0]      wprod;
  logic [ACC_W-1:0] acc_nxt;
  logic             better;
  logic [ACC_W-1:0] best_nxt;
  logic [CNT_W:0]   div_t;
  logic             div_bit;
  logic [DS_W-1:0]  quo;
  logic [47:0]      change;
  logic [SUM_W-1:0] sum_mag;
  logic [SUM_W-1:0] cw_q;
  logic             div_last, stop_hit, train_done, idle_rsp, rsp_set;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // request range checks
  assign in_vec_ok = ({1'b0, in_data.vec_index} < n_r) &&
                     (32'(in_data.vec_index) < kmtc_pkg::TRAIN_MAX) &&
                     (32'(in_data.dim_index) < DIMS);
  assign in_cw_ok  = (13'(in_data.vec_index) < 13'(k_r)) &&
                     (32'(in_data.vec_index) < kmtc_pkg::CODEBOOK_MAX) &&
                     (32'(in_data.dim_index) < DIMS);
  assign start_ok  = (k_r != 6'd0) && (32'(k_r) <= kmtc_pkg::CODEBOOK_MAX) &&
                     (n_r != 13'd0) && (32'(n_r) <= kmtc_pkg::TRAIN_MAX);
  assign in_taddr  = TA_W'(32'(in_data.vec_index) * DIMS + 32'(in_data.dim_index));
  assign in_caddr  = CA_W'(32'(in_data.vec_index) * DIMS + 32'(in_data.dim_index));

  assign last_d   = (32'(d_r) == DIMS - 1);
  assign last_j   = (6'(j_r) == k_r - 6'd1);
  assign last_v   = (13'(v_r) == n_r - 13'd1);
  assign last_clr = (32'(clr_r) == 32'(k_r) * DIMS - 1);

  // weighted square and running distance
  assign diff     = 17'($signed(cb_rdata)) - 17'($signed(tr_rdata));
  assign wprod    = sq_r * kmtc_pkg::weight_of(d_r);
  assign acc_nxt  = acc_r + ACC_W'(wprod);
  // first minimum wins: strictly less replaces
  assign better   = (j_r == '0) || (acc_nxt < best_r);
  assign best_nxt = better ? acc_nxt : best_r;

  // one restoring step of the divider
  assign div_t   = {rem_r, num_r[DS_W-1]};
  assign div_bit = (div_t >= {1'b0, den_r});
  assign quo     = {num_r[DS_W-2:0], div_bit};
  assign change  = (quo[47:0] >= prev_r) ? quo[47:0] - prev_r : prev_r - quo[47:0];
  assign sum_mag = sm_rdata[SUM_W-1] ? SUM_W'(-$signed(sm_rdata)) : sm_rdata;
  assign cw_q    = neg_r ? SUM_W'(-quo[SUM_W-1:0]) : quo[SUM_W-1:0];

  // when a result gets loaded into the output register
  assign div_last   = (32'(div_cnt_r) == DS_W - 1);
  assign stop_hit   = (change <= 48'(thr_r));
  assign train_done = (state_r == S_DIV) && div_last && div_avg_r && !first_r &&
                      (stop_hit || 32'(pc_r) >= kmtc_pkg::MAX_ITER);
  assign idle_rsp   = accept &&
                      !(((in_data.req_type == kmtc_pkg::REQ_READ_CODE) && in_cw_ok) ||
                        ((in_data.req_type == kmtc_pkg::REQ_START) && start_ok));
  assign rsp_set    = ((state_r == S_IDLE) && idle_rsp) || (state_r == S_RDW) || train_done;

  // ram address and write selection
  always_comb begin
    tr_we    = accept && (in_data.req_type == kmtc_pkg::REQ_LOAD_TRAIN) && in_vec_ok;
    tr_waddr = in_taddr;
    tr_raddr = tv_base_r + TA_W'(d_r);

    cb_we    = 1'b0;
    cb_waddr = in_caddr;
    cb_wdata = in_data.coef_value;
    cb_raddr = cb_base_r + CA_W'(d_r);
    if (state_r == S_IDLE) begin
      cb_raddr = in_caddr;
      cb_we    = accept && (in_data.req_type == kmtc_pkg::REQ_LOAD_CODE) && in_cw_ok;
    end else if (state_r == S_CW) begin
      cb_we    = 1'b1;
      cb_waddr = cb_base_r + CA_W'(d_r);
      cb_wdata = cw_val_r;
    end

    sm_we    = 1'b0;
    sm_waddr = bj_base_r + CA_W'(d_r);
    sm_wdata = sm_rdata + SUM_W'($signed(tr_rdata));
    sm_raddr = (state_r == S_CS) ? cb_base_r + CA_W'(d_r) : bj_base_r + CA_W'(d_r);

    ct_we    = 1'b0;
    ct_waddr = bj_r;
    ct_wdata = ct_rdata + CNT_W'(1);
    ct_raddr = (state_r == S_CA) ? j_r : bj_r;

    case (state_r)
      S_CLR: begin
        sm_we    = 1'b1;
        sm_waddr = clr_r;
        sm_wdata = '0;
        ct_we    = (32'(clr_r) < 32'(k_r));
        ct_waddr = J_W'(clr_r);
        ct_wdata = '0;
      end
      S_UWR: begin
        sm_we = 1'b1;
        ct_we = (d_r == '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= 6'd8;
      n_r         <= 13'd4096;
      thr_r       <= 32'd168;
      pc_r        <= '0;
      prev_r      <= '0;
      dsum_r      <= '0;
      first_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          kmtc_pkg::CFG_CODEBOOK_SIZE:  k_r   <= cfg_wdata[5:0];
          kmtc_pkg::CFG_TRAINING_COUNT: n_r   <= cfg_wdata[12:0];
          kmtc_pkg::CFG_STOP_THRESHOLD: thr_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (rsp_set) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_data.req_type)
              kmtc_pkg::REQ_LOAD_TRAIN: begin
                out_data_r <= '{status: (in_vec_ok ? kmtc_pkg::ST_OK : kmtc_pkg::ST_RANGE),
                                default: '0};
              end
              kmtc_pkg::REQ_LOAD_CODE: begin
                out_data_r <= '{status: (in_cw_ok ? kmtc_pkg::ST_OK : kmtc_pkg::ST_RANGE),
                                default: '0};
              end
              kmtc_pkg::REQ_READ_CODE: begin
                if (in_cw_ok) begin
                  state_r <= S_RDW;
                end else begin
                  out_data_r <= '{status: kmtc_pkg::ST_RANGE, default: '0};
                end
              end
              default: begin
                if (start_ok) begin
                  clr_r   <= '0;
                  first_r <= 1'b1;
                  state_r <= S_CLR;
                end else begin
                  out_data_r <= '{status: kmtc_pkg::ST_RANGE, default: '0};
                end
              end
            endcase
          end
        end
        S_RDW: begin
          out_data_r <= '{status: kmtc_pkg::ST_OK, read_value: cb_rdata, default: '0};
          state_r    <= S_IDLE;
        end
        // clear sums and counts of the codewords in use
        S_CLR: begin
          clr_r <= clr_r + CA_W'(1);
          if (last_clr) begin
            dsum_r    <= '0;
            v_r       <= '0;
            j_r       <= '0;
            d_r       <= '0;
            acc_r     <= '0;
            tv_base_r <= '0;
            cb_base_r <= '0;
            state_r   <= S_DADDR;
          end
        end
        S_DADDR: state_r <= S_DSQ;
        S_DSQ: begin
          sq_r    <= 34'(diff * diff);
          state_r <= S_DACC;
        end
        S_DACC: begin
          if (last_d) begin
            best_r <= best_nxt;
            if (better) begin
              bj_r      <= j_r;
              bj_base_r <= cb_base_r;
            end
            acc_r <= '0;
            d_r   <= '0;
            if (last_j) begin
              dsum_r  <= dsum_r + DS_W'(best_nxt);
              state_r <= S_UADDR;
            end else begin
              j_r       <= j_r + J_W'(1);
              cb_base_r <= cb_base_r + CA_W'(DIMS);
              state_r   <= S_DADDR;
            end
          end else begin
            acc_r   <= acc_nxt;
            d_r     <= d_r + D_W'(1);
            state_r <= S_DADDR;
          end
        end
        S_UADDR: state_r <= S_UWR;
        // read-modify-write of the winning cluster's sums and count
        S_UWR: begin
          if (last_d) begin
            d_r <= '0;
            if (last_v) begin
              num_r     <= dsum_r;
              den_r     <= n_r;
              rem_r     <= '0;
              div_cnt_r <= '0;
              div_avg_r <= 1'b1;
              state_r   <= S_DIV;
            end else begin
              v_r       <= v_r + (V_W+1)'(1);
              tv_base_r <= tv_base_r + TA_W'(DIMS);
              j_r       <= '0;
              cb_base_r <= '0;
              acc_r     <= '0;
              state_r   <= S_DADDR;
            end
          end else begin
            d_r     <= d_r + D_W'(1);
            state_r <= S_UADDR;
          end
        end
        S_DIV: begin
          num_r     <= quo;
          rem_r     <= div_bit ? CNT_W'(div_t - {1'b0, den_r}) : CNT_W'(div_t);
          div_cnt_r <= div_cnt_r + DIV_CW'(1);
          if (div_last) begin
            if (div_avg_r) begin
              j_r       <= '0;
              cb_base_r <= '0;
              if (first_r) begin
                pc_r    <= PC_W'(1);
                prev_r  <= quo[47:0];
                state_r <= S_CA;
              end else if (train_done) begin
                out_data_r <= '{status: (stop_hit ? kmtc_pkg::ST_OK : kmtc_pkg::ST_LIMIT),
                                read_value: '0,
                                avg_distortion: quo[47:0],
                                iterations: 8'(pc_r)};
                state_r    <= S_IDLE;
              end else begin
                pc_r    <= pc_r + PC_W'(1);
                prev_r  <= quo[47:0];
                state_r <= S_CA;
              end
            end else begin
              cw_val_r <= cw_q[15:0];
              state_r  <= S_CW;
            end
          end
        end
        // centroid update, empty clusters skipped
        S_CA: state_r <= S_CC;
        S_CC: begin
          if (ct_rdata == '0) begin
            if (last_j) begin
              clr_r   <= '0;
              first_r <= 1'b0;
              state_r <= S_CLR;
            end else begin
              j_r       <= j_r + J_W'(1);
              cb_base_r <= cb_base_r + CA_W'(DIMS);
              state_r   <= S_CA;
            end
          end else begin
            cnt_r   <= ct_rdata;
            d_r     <= '0;
            state_r <= S_CS;
          end
        end
        S_CS: state_r <= S_CD;
        S_CD: begin
          num_r     <= DS_W'(sum_mag);
          den_r     <= cnt_r;
          neg_r     <= sm_rdata[SUM_W-1];
          rem_r     <= '0;
          div_cnt_r <= '0;
          div_avg_r <= 1'b0;
          state_r   <= S_DIV;
        end
        S_CW: begin
          if (last_d) begin
            d_r <= '0;
            if (last_j) begin
              clr_r   <= '0;
              first_r <= 1'b0;
              state_r <= S_CLR;
            end else begin
              j_r       <= j_r + J_W'(1);
              cb_base_r <= cb_base_r + CA_W'(DIMS);
              state_r   <= S_CA;
            end
          end else begin
            d_r     <= d_r + D_W'(1);
            state_r <= S_CS;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  kmtc_ram #(.WIDTH(16), .DEPTH(kmtc_pkg::TRAIN_MAX * DIMS)) u_train (
    .clk(clk), .we(tr_we), .waddr(tr_waddr), .wdata(in_data.coef_value),
    .raddr(tr_raddr), .rdata(tr_rdata)
  );
  kmtc_ram #(.WIDTH(16), .DEPTH(kmtc_pkg::CODEBOOK_MAX * DIMS)) u_code (
    .clk(clk), .we(cb_we), .waddr(cb_waddr), .wdata(cb_wdata),
    .raddr(cb_raddr), .rdata(cb_rdata)
  );
  kmtc_ram #(.WIDTH(SUM_W), .DEPTH(kmtc_pkg::CODEBOOK_MAX * DIMS)) u_sums (
    .clk(clk), .we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata),
    .raddr(sm_raddr), .rdata(sm_rdata)
  );
  kmtc_ram #(.WIDTH(CNT_W), .DEPTH(kmtc_pkg::CODEBOOK_MAX)) u_cnts (
    .clk(clk), .we(ct_we), .waddr(ct_waddr), .wdata(ct_wdata),
    .raddr(ct_raddr), .rdata(ct_rdata)
  );

  // a stalled result stays until taken
  `KMTC_ASSERT(a_out_hold, (out_valid && out_stall) |=> out_valid, "result dropped while stalled")
  // no request is taken while a job is running
  `KMTC_ASSERT(a_idle_accept, accept |-> (state_r == S_IDLE), "request taken while busy")
  // the divider never runs on a zero divisor
  `KMTC_ASSERT(a_div_den, (state_r == S_DIV) |-> (den_r != '0), "divide by zero")
  // update count stays within the limit
  `KMTC_ASSERT(a_pc_limit, 32'(pc_r) <= kmtc_pkg::MAX_ITER, "iteration count past limit")
endmodule

### tb/sv/tb_kmeans_tokhura_codebook_trainer_unit.sv
// testbench of the k-means codebook trainer: random loads, reads and trainings
module tb_kmeans_tokhura_codebook_trainer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000000;
  localparam int RANDOM_ITEMS = 650;
  localparam int TMAX = kmtc_pkg::TRAIN_MAX;
  localparam int CMAX = kmtc_pkg::CODEBOOK_MAX;
  localparam int DIMS = kmtc_pkg::DIMENSIONS;

  // predictor of the trainer plus the queue of responses it has worked out
  class trainer_scoreboard;
    shortint     train_mem[TMAX*DIMS];
    shortint     code_mem[CMAX*DIMS];
    longint      cl_sum[CMAX*DIMS];
    int unsigned cl_cnt[CMAX];
    int unsigned wt[12] = '{1, 3, 7, 13, 19, 22, 25, 33, 42, 50, 56, 61};
    int unsigned k_cfg = 8;
    int unsigned n_cfg = 4096;
    int unsigned thr_cfg = 168;
    kmtc_pkg::rsp_t pending[$];
    int          errors = 0;

    function void write_cfg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        kmtc_pkg::CFG_CODEBOOK_SIZE:  k_cfg = 32'(val[5:0]);
        kmtc_pkg::CFG_TRAINING_COUNT: n_cfg = 32'(val[12:0]);
        kmtc_pkg::CFG_STOP_THRESHOLD: thr_cfg = val;
        default: ;
      endcase
    endfunction

    function longint unsigned weighted_dist(int cw, int tv);
      longint unsigned acc;
      longint diff;
      acc = 0;
      for (int d = 0; d < DIMS; d++) begin
        diff = longint'(code_mem[cw*DIMS+d]) - longint'(train_mem[tv*DIMS+d]);
        acc += longint'(diff * diff) * (d < 12 ? wt[d] : 61);
      end
      return acc;
    endfunction

    // one assignment pass, returns mean distortion
    function longint unsigned assign_vectors(int k, int n);
      longint unsigned total, best, cand;
      int bj;
      total = 0;
      for (int i = 0; i < k*DIMS; i++) cl_sum[i] = 0;
      for (int j = 0; j < k; j++) cl_cnt[j] = 0;
      for (int v = 0; v < n; v++) begin
        best = weighted_dist(0, v);
        bj = 0;
        for (int j = 1; j < k; j++) begin
          cand = weighted_dist(j, v);
          if (cand < best) begin
            best = cand;
            bj = j;
          end
        end
        total += best;
        cl_cnt[bj]++;
        for (int d = 0; d < DIMS; d++)
          cl_sum[bj*DIMS+d] += train_mem[v*DIMS+d];
      end
      return (total / n) & 64'hFFFF_FFFF_FFFF;
    endfunction

    function void move_centroids(int k);
      for (int j = 0; j < k; j++) begin
        if (cl_cnt[j] != 0) begin
          for (int d = 0; d < DIMS; d++)
            code_mem[j*DIMS+d] = shortint'(cl_sum[j*DIMS+d] / longint'(cl_cnt[j]));
        end
      end
    endfunction

    function void note_request(kmtc_pkg::req_t r);
      kmtc_pkg::rsp_t e;
      longint unsigned avg, prev, chg;
      int passes;
      e = '0;
      case (r.req_type)
        kmtc_pkg::REQ_LOAD_TRAIN: begin
          if (r.vec_index < n_cfg && r.vec_index < TMAX && r.dim_index < DIMS)
            train_mem[r.vec_index*DIMS+r.dim_index] = r.coef_value;
          else
            e.status = kmtc_pkg::ST_RANGE;
        end
        kmtc_pkg::REQ_LOAD_CODE, kmtc_pkg::REQ_READ_CODE: begin
          if (r.vec_index < k_cfg && r.vec_index < CMAX && r.dim_index < DIMS) begin
            if (r.req_type == kmtc_pkg::REQ_LOAD_CODE)
              code_mem[r.vec_index*DIMS+r.dim_index] = r.coef_value;
            else
              e.read_value = code_mem[r.vec_index*DIMS+r.dim_index];
          end else begin
            e.status = kmtc_pkg::ST_RANGE;
          end
        end
        default: begin
          if (k_cfg == 0 || k_cfg > CMAX || n_cfg == 0 || n_cfg > TMAX) begin
            e.status = kmtc_pkg::ST_RANGE;
          end else begin
            avg = assign_vectors(k_cfg, n_cfg);
            passes = 0;
            forever begin
              passes++;
              prev = avg;
              move_centroids(k_cfg);
              avg = assign_vectors(k_cfg, n_cfg);
              chg = (avg >= prev) ? avg - prev : prev - avg;
              if (chg <= longint'(thr_cfg)) break;
              if (passes >= kmtc_pkg::MAX_ITER) begin
                e.status = kmtc_pkg::ST_LIMIT;
                break;
              end
            end
            e.avg_distortion = avg[47:0];
            e.iterations = passes[7:0];
          end
        end
      endcase
      pending = {pending, e};
    endfunction

    function void check_response(kmtc_pkg::rsp_t a);
      kmtc_pkg::rsp_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response %p", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
        errors++;
      end
      if (a.read_value !== e.read_value) begin
        $display("%0t: read_value expected %0d actual %0d", $time, e.read_value, a.read_value);
        errors++;
      end
      if (a.avg_distortion !== e.avg_distortion) begin
        $display("%0t: avg_distortion expected %0d actual %0d", $time,
                 e.avg_distortion, a.avg_distortion);
        errors++;
      end
      if (a.iterations !== e.iterations) begin
        $display("%0t: iterations expected %0d actual %0d", $time, e.iterations, a.iterations);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  kmtc_pkg::req_t in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  kmtc_pkg::rsp_t out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = kmtc_pkg::CFG_CODEBOOK_SIZE;
  logic [31:0] cfg_wdata = '0;

  trainer_scoreboard sb = new();
  // which entries hold defined data, so no start or read touches an unwritten one
  bit train_loaded[TMAX*DIMS];
  bit code_loaded[CMAX*DIMS];
  bit calm = 1'b0;         // no idling on either side while set
  int sent = 0;
  int unsigned cycles = 0;

  always #5 clk = ~clk;

  kmeans_tokhura_codebook_trainer_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // result side: random stall, check each accepted item
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_response(out_data);
    out_stall <= !calm && ($urandom_range(99) < 30);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_kmeans_tokhura_codebook_trainer_unit: FAIL");
      $finish;
    end
  end

  // hand one item over, with a random gap in front of it
  task automatic send(logic [1:0] rt, int vi, int di, logic [15:0] cv);
    kmtc_pkg::req_t r;
    r.req_type = rt;
    r.vec_index = vi[11:0];
    r.dim_index = di[3:0];
    r.coef_value = cv;
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // mark defined entries before the predictor sees the item
    if (rt == kmtc_pkg::REQ_LOAD_TRAIN && vi < sb.n_cfg && di < DIMS)
      train_loaded[vi*DIMS+di] = 1'b1;
    if (rt == kmtc_pkg::REQ_LOAD_CODE && vi < sb.k_cfg && vi < CMAX && di < DIMS)
      code_loaded[vi*DIMS+di] = 1'b1;
    sb.note_request(r);
    sent++;
  endtask

  // register write once the block has drained
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_cfg(idx, val);
  endtask

  // make every entry a start will touch defined
  task automatic fill_sets();
    for (int v = 0; v < sb.n_cfg; v++)
      for (int d = 0; d < DIMS; d++)
        if (!train_loaded[v*DIMS+d]) send(kmtc_pkg::REQ_LOAD_TRAIN, v, d, 16'($urandom));
    for (int j = 0; j < sb.k_cfg; j++)
      for (int d = 0; d < DIMS; d++)
        if (!code_loaded[j*DIMS+d]) send(kmtc_pkg::REQ_LOAD_CODE, j, d, 16'($urandom));
  endtask

  // one read of a defined codeword entry, if any
  task automatic read_some();
    int j, d;
    j = $urandom_range(sb.k_cfg - 1);
    d = $urandom_range(DIMS - 1);
    if (code_loaded[j*DIMS+d]) send(kmtc_pkg::REQ_READ_CODE, j, d, 16'($urandom));
  endtask

  // loads, reads and out-of-range requests between trainings
  task automatic noise_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 35)
      send(kmtc_pkg::REQ_LOAD_TRAIN, $urandom_range(sb.n_cfg - 1), $urandom_range(DIMS - 1),
           16'($urandom));
    else if (pick < 60)
      send(kmtc_pkg::REQ_LOAD_CODE, $urandom_range(sb.k_cfg - 1), $urandom_range(DIMS - 1),
           16'($urandom));
    else if (pick < 80)
      read_some();
    else if (pick < 90)
      // any index, with a dimension past the last
      send(2'(kmtc_pkg::REQ_LOAD_TRAIN + $urandom_range(1)), $urandom_range(4095),
           $urandom_range(12, 15), 16'($urandom));
    else
      send($urandom_range(1) ? kmtc_pkg::REQ_READ_CODE : kmtc_pkg::REQ_LOAD_CODE,
           $urandom_range(sb.k_cfg, 4095), $urandom_range(15), 16'($urandom));
  endtask

  initial begin
    int k, n, nz;
    bit big_done;
    big_done = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes under reset sizes
    send(kmtc_pkg::REQ_LOAD_TRAIN, 4095, 11, 16'h8000);
    send(kmtc_pkg::REQ_LOAD_TRAIN, 4095, 12, 16'h7fff);
    send(kmtc_pkg::REQ_LOAD_TRAIN, 0, 15, 16'hffff);
    send(kmtc_pkg::REQ_LOAD_CODE, 7, 0, 16'h7fff);
    send(kmtc_pkg::REQ_LOAD_CODE, 0, 11, 16'h8000);
    send(kmtc_pkg::REQ_READ_CODE, 7, 0, 16'h0000);
    send(kmtc_pkg::REQ_READ_CODE, 0, 11, 16'hffff);
    send(kmtc_pkg::REQ_READ_CODE, 8, 0, 16'h0000);
    send(kmtc_pkg::REQ_READ_CODE, 4095, 3, 16'h0000);
    send(kmtc_pkg::REQ_LOAD_CODE, 32, 1, 16'h1234);
    // bad sizes at start
    write_reg(kmtc_pkg::CFG_CODEBOOK_SIZE, 0);
    send(kmtc_pkg::REQ_START, 0, 0, 16'h0000);
    write_reg(kmtc_pkg::CFG_CODEBOOK_SIZE, 63);
    send(kmtc_pkg::REQ_START, 4095, 15, 16'hffff);
    write_reg(kmtc_pkg::CFG_CODEBOOK_SIZE, 33);
    send(kmtc_pkg::REQ_START, 0, 0, 16'h0000);
    write_reg(kmtc_pkg::CFG_CODEBOOK_SIZE, 2);
    write_reg(kmtc_pkg::CFG_TRAINING_COUNT, 0);
    send(kmtc_pkg::REQ_START, 0, 0, 16'h0000);
    write_reg(kmtc_pkg::CFG_TRAINING_COUNT, 4097);
    send(kmtc_pkg::REQ_START, 0, 0, 16'h0000);
    write_reg(kmtc_pkg::CFG_TRAINING_COUNT, 8191);
    send(kmtc_pkg::REQ_START, 0, 0, 16'h0000);
    // smallest sets, zero threshold: single codeword, single vector
    write_reg(kmtc_pkg::CFG_CODEBOOK_SIZE, 1);
    write_reg(kmtc_pkg::CFG_TRAINING_COUNT, 1);
    write_reg(kmtc_pkg::CFG_STOP_THRESHOLD, 0);
    fill_sets();
    send(kmtc_pkg::REQ_START, 0, 0, 16'h0000);
    send(kmtc_pkg::REQ_READ_CODE, 0, 5, 16'h0000);

    // random phases: sizes, threshold, noise, start; one mid stretch without idling
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = (sent > RANDOM_ITEMS / 3 && sent < RANDOM_ITEMS / 2);
      if (!big_done && sent > RANDOM_ITEMS / 3) begin
        k = 32;
        n = 20;
        big_done = 1'b1;
      end else begin
        k = $urandom_range(1, 4);
        n = $urandom_range(1, 12);
      end
      write_reg(kmtc_pkg::CFG_CODEBOOK_SIZE, k);
      write_reg(kmtc_pkg::CFG_TRAINING_COUNT, n);
      case ($urandom_range(2))
        0: write_reg(kmtc_pkg::CFG_STOP_THRESHOLD, (k == 1) ? 0 : $urandom_range(50, 200000));
        1: write_reg(kmtc_pkg::CFG_STOP_THRESHOLD, 32'hffff_ffff);
        default: write_reg(kmtc_pkg::CFG_STOP_THRESHOLD, $urandom_range(0, 5000) + 100);
      endcase
      nz = $urandom_range(5, 30);
      for (int i = 0; i < nz; i++) noise_item();
      fill_sets();
      send(kmtc_pkg::REQ_START, $urandom_range(4095), $urandom_range(15), 16'($urandom));
      for (int i = 0; i < 3; i++) read_some();
    end
    calm = 1'b0;

    // full training count at the top of its range, loads only
    write_reg(kmtc_pkg::CFG_TRAINING_COUNT, 4096);
    send(kmtc_pkg::REQ_LOAD_TRAIN, 4095, 0, 16'($urandom));
    send(kmtc_pkg::REQ_LOAD_TRAIN, 2048, 7, 16'($urandom));
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("tb_kmeans_tokhura_codebook_trainer_unit: PASS");
    else
      $display("tb_kmeans_tokhura_codebook_trainer_unit: FAIL");
    $finish;
  end
endmodule
